// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/hsl2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Types, constants and small functions shared by the HSL to RGB pipeline.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    // Input transfer: one color.
    typedef struct packed {
        logic [9:0] hue_degrees;
        logic [6:0] saturation_pct;
        logic [6:0] lightness_pct;
    } t_hsl_in;

    // Output transfer: one RGB triple.
    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_rgb_out;

    // Stage advance enables, one per pipeline register.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_stage_en;

    // Stage 1 result: reduced hue, capped percentages.
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] lit;
        logic       grey;
    } t_prep;

    // Stage 2 result: high and low terms, grey product, ramp positions.
    typedef struct packed {
        logic [13:0] hi;
        logic [13:0] lo;
        logic [14:0] grey_x;
        logic [5:0]  pos_r;
        logic [5:0]  pos_g;
        logic [5:0]  pos_b;
        logic        grey;
    } t_terms;

    localparam logic [9:0]  HUE_FULL     = 10'd360;
    localparam logic [9:0]  HUE_DOUBLE   = 10'd720;
    localparam logic [6:0]  PCT_MAX      = 7'd100;
    localparam logic [6:0]  PCT_HALF     = 7'd50;
    localparam logic [8:0]  HUE_60       = 9'd60;
    localparam logic [8:0]  HUE_120      = 9'd120;
    localparam logic [8:0]  HUE_180      = 9'd180;
    localparam logic [8:0]  HUE_240      = 9'd240;
    localparam logic [5:0]  SEXTANT      = 6'd60;
    localparam logic [19:0] RAMP_FULL    = 20'd600000;
    // ceil(2^19 / 100): grey level = (l * 255 * RECIP_100) >> 19.
    localparam logic [12:0] RECIP_100    = 13'd5243;
    // ceil(2^40 / 40000): level = (ramp * 17 * RECIP_40K) >> 40.
    localparam logic [24:0] RECIP_40K    = 25'd27487791;

    // Position along the channel ramp, 0 .. 60.
    function automatic logic [5:0] ramp_pos(input logic [8:0] hue);
        logic [8:0] down;
        down = HUE_240 - hue;
        if (hue < HUE_60) begin
            return hue[5:0];
        end else if (hue < HUE_180) begin
            return SEXTANT;
        end else if (hue < HUE_240) begin
            return down[5:0];
        end else begin
            return 6'd0;
        end
    endfunction

    // ramp * 255 / 600000 equals ramp * 17 / 40000, done by reciprocal.
    function automatic logic [7:0] scale_level(input logic [19:0] ramp);
        logic [23:0] y;
        logic [48:0] p;
        y = {ramp, 4'b0000} + {4'b0000, ramp};
        p = 49'(y) * 49'(RECIP_40K);
        return p[47:40];
    endfunction

endpackage

// ----- rtl/hsl2rgb_prep.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_prep
// First stage: hue modulo 360, saturation and lightness capped at 100.
// ----------------------------------------------------------------------------
module hsl2rgb_prep
    import hsl2rgb_pkg::*;
(
    input  logic      i_clk,
    input  t_stage_en i_en,
    input  t_hsl_in   i_data,
    output t_prep     o_prep
);

    t_prep      r_prep;
    t_prep      n_prep;
    logic [9:0] w_hue;

    always_comb begin
        // The input hue stays below 1024, so two subtractions cover it.
        if (i_data.hue_degrees >= HUE_DOUBLE) begin
            w_hue = i_data.hue_degrees - HUE_DOUBLE;
        end else if (i_data.hue_degrees >= HUE_FULL) begin
            w_hue = i_data.hue_degrees - HUE_FULL;
        end else begin
            w_hue = i_data.hue_degrees;
        end
        n_prep.hue  = w_hue[8:0];
        n_prep.sat  = (i_data.saturation_pct > PCT_MAX) ? PCT_MAX : i_data.saturation_pct;
        n_prep.lit  = (i_data.lightness_pct > PCT_MAX) ? PCT_MAX : i_data.lightness_pct;
        n_prep.grey = (i_data.saturation_pct == 7'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

// ----- rtl/hsl2rgb_terms.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_terms
// Second stage: high and low terms, grey product and per-channel ramp
// positions for the rotated hues.
// ----------------------------------------------------------------------------
module hsl2rgb_terms
    import hsl2rgb_pkg::*;
(
    input  logic      i_clk,
    input  t_stage_en i_en,
    input  t_prep     i_prep,
    output t_terms    o_terms
);

    t_terms      r_terms;
    t_terms      n_terms;
    logic [14:0] w_l;
    logic [14:0] w_s;
    logic [14:0] w_hi_dark;
    logic [14:0] w_hi_light;
    logic [14:0] w_hi;
    logic [14:0] w_lo;
    logic [8:0]  w_hue_r;
    logic [8:0]  w_hue_b;

    always_comb begin
        w_l        = 15'(i_prep.lit);
        w_s        = 15'(i_prep.sat);
        w_hi_dark  = w_l * (15'(PCT_MAX) + w_s);
        w_hi_light = (w_l + w_s) * 15'(PCT_MAX) - w_s * w_l;
        w_hi       = (i_prep.lit < PCT_HALF) ? w_hi_dark : w_hi_light;
        // Both terms stay within 0 .. 10000.
        w_lo       = w_l * 15'd200 - w_hi;

        w_hue_r = (i_prep.hue < HUE_240) ? i_prep.hue + HUE_120 : i_prep.hue - HUE_240;
        w_hue_b = (i_prep.hue >= HUE_120) ? i_prep.hue - HUE_120 : i_prep.hue + HUE_240;

        n_terms.hi     = w_hi[13:0];
        n_terms.lo     = w_lo[13:0];
        n_terms.grey_x = w_l * 15'd255;
        n_terms.pos_r  = ramp_pos(w_hue_r);
        n_terms.pos_g  = ramp_pos(i_prep.hue);
        n_terms.pos_b  = ramp_pos(w_hue_b);
        n_terms.grey   = i_prep.grey;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

// ----- rtl/hsl2rgb_ramp.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_ramp
// Third stage for one channel: ramp value lo * 60 + (hi - lo) * position,
// in units of 1/600000.
// ----------------------------------------------------------------------------
module hsl2rgb_ramp
    import hsl2rgb_pkg::*;
(
    input  logic        i_clk,
    input  t_stage_en   i_en,
    input  logic [13:0] i_hi,
    input  logic [13:0] i_lo,
    input  logic [5:0]  i_pos,
    output logic [19:0] o_ramp
);

    logic [19:0] r_ramp;
    logic [19:0] n_ramp;
    logic [13:0] w_diff;

    always_comb begin
        w_diff = i_hi - i_lo;
        n_ramp = 20'(i_lo) * 20'(SEXTANT) + 20'(w_diff) * 20'(i_pos);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_ramp <= n_ramp;
        end
    end

    assign o_ramp = r_ramp;

endmodule

// ----- rtl/hsl_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Integer HSL to RGB conversion, four register stages.
//
//   Channel  Direction  Handshake                    Payload
//   input    in         i_in_valid / o_in_ready      i_in_data  (t_hsl_in)
//   output   out        o_out_valid / i_out_ready    o_out_data (t_rgb_out)
//
// One color per clock while the output is not stalled; a result passes the prep,
// terms, ramp and output registers before it is offered at the output.
// Stages: hue reduction and caps, term products, channel ramps, scaling by
// reciprocal multiplication into the output register.
// Reset clears only the stage valid bits.
// A stage advances when it is empty or the stage after it advances, so
// bubbles close up while the output is stalled and nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_hsl_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_rgb_out o_out_data
);

    t_stage_en   w_en;
    t_prep       w_prep;
    t_terms      w_terms;
    logic [19:0] w_ramp_r;
    logic [19:0] w_ramp_g;
    logic [19:0] w_ramp_b;

    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        r_v4;
    logic [27:0] r_grey_prod;
    logic        r_grey3;
    logic        r_grey4;
    t_rgb_out    r_out;
    t_rgb_out    n_out;

    always_comb begin
        w_en.en4 = !r_v4 || i_out_ready;
        w_en.en3 = !r_v3 || w_en.en4;
        w_en.en2 = !r_v2 || w_en.en3;
        w_en.en1 = !r_v1 || w_en.en2;
    end

    assign o_in_ready = w_en.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en.en1) begin
                r_v1 <= i_in_valid;
            end
            if (w_en.en2) begin
                r_v2 <= r_v1;
            end
            if (w_en.en3) begin
                r_v3 <= r_v2;
            end
            if (w_en.en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    hsl2rgb_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (i_in_data),
        .o_prep (w_prep)
    );

    hsl2rgb_terms u_terms (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_prep  (w_prep),
        .o_terms (w_terms)
    );

    hsl2rgb_ramp u_ramp_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_hi   (w_terms.hi),
        .i_lo   (w_terms.lo),
        .i_pos  (w_terms.pos_r),
        .o_ramp (w_ramp_r)
    );

    hsl2rgb_ramp u_ramp_g (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_hi   (w_terms.hi),
        .i_lo   (w_terms.lo),
        .i_pos  (w_terms.pos_g),
        .o_ramp (w_ramp_g)
    );

    hsl2rgb_ramp u_ramp_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_hi   (w_terms.hi),
        .i_lo   (w_terms.lo),
        .i_pos  (w_terms.pos_b),
        .o_ramp (w_ramp_b)
    );

    // Grey path runs alongside the channel ramps: (l * 255) / 100 by reciprocal.
    always_ff @(posedge i_clk) begin
        if (w_en.en3) begin
            r_grey_prod <= 28'(w_terms.grey_x) * 28'(RECIP_100);
            r_grey3     <= w_terms.grey;
        end
    end

    always_comb begin
        if (r_grey3) begin
            n_out.red_level   = r_grey_prod[26:19];
            n_out.green_level = r_grey_prod[26:19];
            n_out.blue_level  = r_grey_prod[26:19];
        end else begin
            n_out.red_level   = scale_level(w_ramp_r);
            n_out.green_level = scale_level(w_ramp_g);
            n_out.blue_level  = scale_level(w_ramp_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en.en4) begin
            r_out   <= n_out;
            r_grey4 <= r_grey3;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = r_out;

    `ASSERT_PROP(a_grey_equal, i_clk, i_rst_n,
        (r_v4 && r_grey4) |-> (r_out.red_level == r_out.green_level
            && r_out.green_level == r_out.blue_level),
        "grey result has unequal channels")
    `ASSERT_PROP(a_ramp_bound, i_clk, i_rst_n,
        (r_v3 && !r_grey3) |-> (w_ramp_r <= RAMP_FULL && w_ramp_g <= RAMP_FULL
            && w_ramp_b <= RAMP_FULL),
        "channel ramp above full scale")
    `ASSERT_NEVER(a_full_accept, i_clk, i_rst_n,
        r_v1 && r_v2 && r_v3 && r_v4 && !i_out_ready && o_in_ready,
        "input ready while the pipeline is full and stalled")
    `ASSERT_PROP(a_drain, i_clk, i_rst_n,
        (r_v4 && i_out_ready && !r_v3) |=> !r_v4,
        "output stage kept a result after its transfer")

endmodule

// ----- tb/hsl_to_rgb_converter_test.sv -----
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_test
// Self-checking bench for the HSL to RGB converter. A directed table covers
// grey, the primaries, hue wrap, the percentage caps and the ramp corners.
// About 1200 random colors follow. Every result is compared with its table value
// or with an integer model of the conversion. Both handshakes idle in random bursts, and the
// output is held off once for a long stretch so that the pipeline backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test
    import hsl2rgb_pkg::*;
();

    localparam int unsigned DEG_TURN     = 360;
    localparam int unsigned PCT_TOP      = 100;
    localparam int unsigned LEVEL_TOP    = 255;
    localparam int unsigned RAMP_TOP     = 600000;
    localparam int unsigned DEG_SEXTANT  = 60;
    localparam int          RANDOM_ITEMS = 1200;
    localparam int          QUIET_TAIL   = 200;
    localparam int          HOLD_AT      = 300;
    localparam int          PAUSE_AT     = 700;
    localparam int          HOLD_CYCLES  = 64;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          MAX_REPORTS  = 10;

    typedef struct {
        t_hsl_in  color;
        bit       known;
        t_rgb_out rgb;
    } t_directed_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_hsl_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_rgb_out o_out_data;

    t_rgb_out      rgb_pending[$];
    t_directed_row directed_rows[$];

    bit tx_idling;
    bit rx_idling;
    bit hold_out_req;
    int fault_count;
    int n_colors_sent;
    int n_results_checked;
    int in_stall_cycles;

    hsl_to_rgb_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One channel of the hue ramp, in units of 1/600000.
    function automatic int unsigned hue_ramp(int unsigned lo, int unsigned hi,
                                             int unsigned h);
        if (h < 60) begin
            return lo * DEG_SEXTANT + (hi - lo) * h;
        end else if (h < 180) begin
            return hi * DEG_SEXTANT;
        end else if (h < 240) begin
            return lo * DEG_SEXTANT + (hi - lo) * (240 - h);
        end else begin
            return lo * DEG_SEXTANT;
        end
    endfunction

    function automatic t_rgb_out convert_hsl(t_hsl_in color);
        int unsigned h, s, l, hi, lo, h_red, h_blue;
        t_rgb_out    rgb;
        h = color.hue_degrees;
        h = h % DEG_TURN;
        s = color.saturation_pct;
        l = color.lightness_pct;
        if (s > PCT_TOP) s = PCT_TOP;
        if (l > PCT_TOP) l = PCT_TOP;
        if (s == 0) begin
            rgb.red_level   = 8'(l * LEVEL_TOP / PCT_TOP);
            rgb.green_level = rgb.red_level;
            rgb.blue_level  = rgb.red_level;
        end else begin
            if (l < 50) begin
                hi = l * (PCT_TOP + s);
            end else begin
                hi = (l + s) * PCT_TOP - s * l;
            end
            lo = l * 200 - hi;
            h_red  = (h < 240) ? h + 120 : h - 240;
            h_blue = (h >= 120) ? h - 120 : h + 240;
            rgb.red_level   = 8'(hue_ramp(lo, hi, h_red) * LEVEL_TOP / RAMP_TOP);
            rgb.green_level = 8'(hue_ramp(lo, hi, h) * LEVEL_TOP / RAMP_TOP);
            rgb.blue_level  = 8'(hue_ramp(lo, hi, h_blue) * LEVEL_TOP / RAMP_TOP);
        end
        return rgb;
    endfunction

    function automatic void add_row(int unsigned h, int unsigned s, int unsigned l,
                                    bit known, int unsigned r, int unsigned g,
                                    int unsigned b);
        t_directed_row row;
        row.color.hue_degrees    = 10'(h);
        row.color.saturation_pct = 7'(s);
        row.color.lightness_pct  = 7'(l);
        row.known                = known;
        row.rgb.red_level        = 8'(r);
        row.rgb.green_level      = 8'(g);
        row.rgb.blue_level       = 8'(b);
        directed_rows.push_back(row);
    endfunction

    // Offers one color, with an optional random gap before it, and records
    // the expected triple once the transfer happens.
    task automatic offer_color(input t_hsl_in color, input t_rgb_out rgb);
        if (tx_idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= color;
        do @(posedge i_clk); while (!o_in_ready);
        rgb_pending.push_back(rgb);
        n_colors_sent++;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_out_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out_req = 1'b0;
            end else if (rx_idling && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_rgb_out want;
        if (i_rst_n && i_in_valid && !o_in_ready) in_stall_cycles++;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rgb_pending.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS) begin
                    $display("Result transfer with nothing expected: r=%0d g=%0d b=%0d",
                             o_out_data.red_level, o_out_data.green_level,
                             o_out_data.blue_level);
                end
            end else begin
                want = rgb_pending.pop_front();
                n_results_checked++;
                if (o_out_data.red_level !== want.red_level
                        || o_out_data.green_level !== want.green_level
                        || o_out_data.blue_level !== want.blue_level) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("Result %0d mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 n_results_checked, want.red_level, want.green_level,
                                 want.blue_level, o_out_data.red_level,
                                 o_out_data.green_level, o_out_data.blue_level);
                    end
                end
            end
        end
    end

    initial begin
        t_hsl_in     color;
        int unsigned pick, edge_hue;
        int unsigned hue_corners[12];

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        tx_idling    = 1'b1;
        rx_idling    = 1'b1;
        hold_out_req = 1'b0;
        hue_corners  = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};

        // Grey, primaries, hue wrap, caps and black/white are easy to read off.
        add_row(0,    0,   0,   1, 0,   0,   0);
        add_row(0,    0,   100, 1, 255, 255, 255);
        add_row(517,  0,   127, 1, 255, 255, 255);
        add_row(1023, 0,   50,  1, 127, 127, 127);
        add_row(0,    100, 50,  1, 255, 0,   0);
        add_row(120,  100, 50,  1, 0,   255, 0);
        add_row(240,  100, 50,  1, 0,   0,   255);
        add_row(360,  100, 50,  1, 255, 0,   0);
        add_row(720,  127, 50,  1, 255, 0,   0);
        add_row(90,   100, 100, 1, 255, 255, 255);
        add_row(1023, 127, 127, 1, 255, 255, 255);
        add_row(1023, 127, 0,   1, 0,   0,   0);
        add_row(200,  100, 0,   1, 0,   0,   0);
        // Ramp corners and the two branches of the high term.
        add_row(59,   100, 50,  0, 0, 0, 0);
        add_row(60,   100, 50,  0, 0, 0, 0);
        add_row(179,  100, 50,  0, 0, 0, 0);
        add_row(180,  100, 50,  0, 0, 0, 0);
        add_row(239,  100, 50,  0, 0, 0, 0);
        add_row(300,  100, 50,  0, 0, 0, 0);
        add_row(359,  100, 50,  0, 0, 0, 0);
        add_row(1023, 1,   1,   0, 0, 0, 0);
        add_row(30,   50,  49,  0, 0, 0, 0);
        add_row(200,  75,  51,  0, 0, 0, 0);
        add_row(600,  60,  25,  0, 0, 0, 0);
        add_row(512,  1,   99,  0, 0, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            offer_color(directed_rows[k].color,
                        directed_rows[k].known ? directed_rows[k].rgb
                                               : convert_hsl(directed_rows[k].color));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Idling alternates in blocks, stays off while the output is
            // held, and is off altogether near the end.
            tx_idling = ((n / 150) % 2 == 0) && !(n >= HOLD_AT && n < HOLD_AT + 150)
                        && (n < RANDOM_ITEMS - QUIET_TAIL);
            rx_idling = ((n / 100) % 2 == 0) && (n < RANDOM_ITEMS - QUIET_TAIL);
            if (n == HOLD_AT) hold_out_req = 1'b1;
            if (n == PAUSE_AT) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (rgb_pending.size() != 0);
            end

            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                color.hue_degrees    = 10'($urandom_range(0, DEG_TURN - 1));
                color.saturation_pct = 7'($urandom_range(1, PCT_TOP));
                color.lightness_pct  = 7'($urandom_range(0, PCT_TOP));
            end else if (pick < 7) begin
                color.hue_degrees    = 10'($urandom);
                color.saturation_pct = 7'($urandom);
                color.lightness_pct  = 7'($urandom);
            end else if (pick == 7) begin
                color.hue_degrees    = 10'($urandom);
                color.saturation_pct = '0;
                color.lightness_pct  = 7'($urandom);
            end else if (pick == 8) begin
                edge_hue = hue_corners[$urandom_range(0, 11)];
                color.hue_degrees = 10'(edge_hue
                                        + DEG_TURN * $urandom_range(0, (1023 - edge_hue) / DEG_TURN));
                color.saturation_pct = 7'($urandom_range(1, 127));
                color.lightness_pct  = 7'($urandom_range(0, 127));
            end else begin
                // Around the lightness midpoint and the caps.
                color.hue_degrees    = 10'($urandom);
                color.saturation_pct = 7'($urandom_range(95, 127));
                color.lightness_pct  = 7'($urandom_range(47, 53) + ($urandom_range(0, 1) ? 50 : 0));
            end
            offer_color(color, convert_hsl(color));
        end

        i_in_valid <= 1'b0;
        while (rgb_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d colors (%0d from the directed table); %0d results checked.",
                 n_colors_sent, directed_rows.size(), n_results_checked);
        $display("Input was back-pressured for %0d cycles, including a %0d-cycle output hold-off.",
                 in_stall_cycles, HOLD_CYCLES);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
